// ===== rtl/sfpb_pkg.sv =====
// Shared types, widths and codes for the seam feather pixel blend.
`default_nettype none

package sfpb_pkg;

  // Column range of the padded panorama.
  localparam int MAX_COLUMNS = 8192;
  localparam int COL_W       = $clog2(MAX_COLUMNS);

  // Pixel channel width.
  localparam int PIX_W = 8;

  // Default feather span in columns.
  localparam int BLEND_SPAN_DEF = 200;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SEAM_COLUMN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = CFG_IDX_W'(1);

  // Stitching direction.
  typedef enum logic {
    DIR_LEFT  = 1'b0,
    DIR_RIGHT = 1'b1
  } dir_t;

  // Stage load enables and occupancy handed to each channel mixer.
  typedef struct packed {
    logic load_sum;
    logic load_quot;
    logic load_out;
    logic sum_valid;
    logic quot_valid;
  } sfpb_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sfpb_mix.sv =====
// One color channel: weighted sum, reciprocal divide and remainder correction.
`default_nettype none

module sfpb_mix #(
  parameter int BLEND_SPAN = sfpb_pkg::BLEND_SPAN_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire sfpb_pkg::sfpb_ctl_t                    ctl,
  input  wire logic [$clog2(BLEND_SPAN+1)-1:0]        weight,
  input  wire logic [sfpb_pkg::PIX_W-1:0]             base,
  input  wire logic [sfpb_pkg::PIX_W-1:0]             warped,
  output logic      [sfpb_pkg::PIX_W-1:0]             result
);
  import sfpb_pkg::*;

  localparam int DIS_W = $clog2(BLEND_SPAN + 1);
  localparam int PRD_W = PIX_W + DIS_W;
  localparam int NUM_W = $clog2(255 * BLEND_SPAN + 1);
  localparam int MUL_W = 2 * NUM_W;
  localparam int RECIP = (2 ** NUM_W) / BLEND_SPAN;

  logic [PRD_W-1:0] prod_base;
  logic [PRD_W-1:0] prod_warp;
  logic [PRD_W:0]   sum_full;
  logic [NUM_W-1:0] num_sum;
  logic [MUL_W-1:0] prod_recip;
  logic [NUM_W-1:0] num_quot;
  logic [PIX_W-1:0] quot;
  logic [PRD_W-1:0] quot_span;
  logic [NUM_W-1:0] rem;
  logic [PIX_W-1:0] result_next;

  // Weighted sum: base weighted by the distance, warped by the rest of the span.
  always_comb begin
    prod_base = PRD_W'(base) * PRD_W'(weight);
    prod_warp = PRD_W'(warped) * PRD_W'(DIS_W'(BLEND_SPAN) - weight);
    sum_full  = (PRD_W + 1)'(prod_base) + (PRD_W + 1)'(prod_warp);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      num_sum <= NUM_W'(sum_full);
    end
  end

  // Quotient estimate by the scaled reciprocal; it is low by at most one.
  assign prod_recip = MUL_W'(num_sum) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load_quot) begin
      quot     <= prod_recip[NUM_W +: PIX_W];
      num_quot <= num_sum;
    end
  end

  // Correction: bump the quotient when the remainder reaches the span.
  always_comb begin
    quot_span   = PRD_W'(quot) * PRD_W'(BLEND_SPAN);
    rem         = num_quot - NUM_W'(quot_span);
    result_next = (rem >= NUM_W'(BLEND_SPAN)) ? quot + PIX_W'(1) : quot;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      result <= result_next;
    end
  end

  // The weighted sum never exceeds full scale times the span.
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    ctl.sum_valid |-> (num_sum <= NUM_W'(255 * BLEND_SPAN)))
    else $error("weighted sum out of range");

  // The reciprocal estimate leaves a remainder below twice the span.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    ctl.quot_valid |-> (rem < NUM_W'(2 * BLEND_SPAN)))
    else $error("quotient estimate off by more than one");

  // The estimate never overshoots the true quotient.
  a_no_overshoot: assert property (@(posedge clk) disable iff (rst)
    ctl.quot_valid |-> (NUM_W'(quot_span) <= num_quot))
    else $error("quotient estimate too large");

endmodule

`default_nettype wire

// ===== rtl/seam_feather_pixel_blend.sv =====
// Top level of the seam feather pixel blend: seam decision stage and pipeline control.
`default_nettype none

// Blends one RGB pixel of the warped image into the panorama at a stitching seam.
// Input channel: in_valid / in_stall with column, base and warped RGB. A request
// is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_red, out_green, out_blue.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// seam_column, index 1 is direction, other indexes are ignored. cfg_ready is
// always high. Write it only while no pixel is in flight.
// An accepted request passes four register stages in order: seam decision,
// weighted sum, reciprocal multiply, remainder correction, then out_valid. The
// block takes one pixel every cycle while out_stall is low.
// When the receiver stalls, each stage holds its pixel and empty stages keep
// filling; in_stall rises only once every stage holds a pixel. Synchronous reset
// empties the pipeline and clears seam_column and direction to zero.
module seam_feather_pixel_blend #(
  parameter int BLEND_SPAN = sfpb_pkg::BLEND_SPAN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write port.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sfpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfpb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Pixel input.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [sfpb_pkg::COL_W-1:0]        column,
  input  wire logic [sfpb_pkg::PIX_W-1:0]        base_red,
  input  wire logic [sfpb_pkg::PIX_W-1:0]        base_green,
  input  wire logic [sfpb_pkg::PIX_W-1:0]        base_blue,
  input  wire logic [sfpb_pkg::PIX_W-1:0]        warped_red,
  input  wire logic [sfpb_pkg::PIX_W-1:0]        warped_green,
  input  wire logic [sfpb_pkg::PIX_W-1:0]        warped_blue,
  // Blended pixel output.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [sfpb_pkg::PIX_W-1:0]             out_red,
  output logic [sfpb_pkg::PIX_W-1:0]             out_green,
  output logic [sfpb_pkg::PIX_W-1:0]             out_blue
);
  import sfpb_pkg::*;

  localparam int DIS_W = $clog2(BLEND_SPAN + 1);
  localparam int SDW   = COL_W + 1;

  logic [COL_W-1:0]            seam_column;
  dir_t                        direction;

  logic                        valid_dec;
  logic                        valid_sum;
  logic                        valid_quot;
  logic                        valid_out;
  logic                        adv_dec;
  logic                        adv_sum;
  logic                        adv_quot;
  logic                        adv_out;

  logic signed [SDW-1:0]       dis;
  logic signed [SDW-1:0]       span;
  logic                        base_on;
  logic                        warp_on;
  logic                        in_band;
  logic                        base_side;
  logic [DIS_W-1:0]            weight_next;
  logic [DIS_W-1:0]            weight;
  logic [2:0][PIX_W-1:0]       base_dec;
  logic [2:0][PIX_W-1:0]       warp_dec;
  logic [2:0][PIX_W-1:0]       mixed;
  sfpb_ctl_t                   ctl;

  // Configuration registers; every write is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seam_column <= '0;
      direction   <= DIR_LEFT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEAM_COLUMN: seam_column <= COL_W'(cfg_data);
        REG_DIRECTION:   direction   <= dir_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage loads when it is empty or its pixel moves on.
  always_comb begin
    adv_out  = !valid_out || !out_stall;
    adv_quot = !valid_quot || adv_out;
    adv_sum  = !valid_sum || adv_quot;
    adv_dec  = !valid_dec || adv_sum;
    in_stall = !adv_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dec  <= 1'b0;
      valid_sum  <= 1'b0;
      valid_quot <= 1'b0;
      valid_out  <= 1'b0;
    end else begin
      if (adv_dec) begin
        valid_dec <= in_valid;
      end
      if (adv_sum) begin
        valid_sum <= valid_dec;
      end
      if (adv_quot) begin
        valid_quot <= valid_sum;
      end
      if (adv_out) begin
        valid_out <= valid_quot;
      end
    end
  end

  // Seam decision: reduce every case to one base weight in zero to the span.
  // Weight zero passes the warped pixel, the full span passes the base pixel.
  always_comb begin
    span    = SDW'(BLEND_SPAN);
    base_on = (base_red | base_green | base_blue) != '0;
    warp_on = (warped_red | warped_green | warped_blue) != '0;
    if (direction == DIR_LEFT) begin
      dis = $signed({1'b0, column}) - $signed({1'b0, seam_column});
    end else begin
      dis = $signed({1'b0, seam_column}) - $signed({1'b0, column});
    end
    in_band = (dis > 0) && (dis < span);
    if (direction == DIR_LEFT) begin
      base_side = dis >= span;
    end else begin
      base_side = (dis == 0) || (dis >= span);
    end
    if (!base_on) begin
      weight_next = '0;
    end else if (!warp_on) begin
      weight_next = DIS_W'(BLEND_SPAN);
    end else if (in_band) begin
      weight_next = DIS_W'(dis);
    end else if (base_side) begin
      weight_next = DIS_W'(BLEND_SPAN);
    end else begin
      weight_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_dec) begin
      weight   <= weight_next;
      base_dec <= {base_blue, base_green, base_red};
      warp_dec <= {warped_blue, warped_green, warped_red};
    end
  end

  // Stage controls for the channel mixers.
  always_comb begin
    ctl.load_sum   = adv_sum;
    ctl.load_quot  = adv_quot;
    ctl.load_out   = adv_out;
    ctl.sum_valid  = valid_sum;
    ctl.quot_valid = valid_quot;
  end

  // One mixer per color channel.
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    sfpb_mix #(
      .BLEND_SPAN(BLEND_SPAN)
    ) u_mix (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .weight (weight),
      .base   (base_dec[ch]),
      .warped (warp_dec[ch]),
      .result (mixed[ch])
    );
  end

  assign out_valid = valid_out;
  assign out_red   = mixed[0];
  assign out_green = mixed[1];
  assign out_blue  = mixed[2];

  // The decided weight never exceeds the span.
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    valid_dec |-> (weight <= DIS_W'(BLEND_SPAN)))
    else $error("blend weight beyond span");

  // A decided pixel that cannot move on keeps its weight.
  a_dec_hold: assert property (@(posedge clk) disable iff (rst)
    valid_dec && !adv_sum |=> valid_dec && $stable(weight))
    else $error("stalled decision stage lost its pixel");

  // With the output stage empty, the pipeline never pushes back on the source.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !valid_out |-> !in_stall)
    else $error("input stalled with an empty output stage");

endmodule

`default_nettype wire

// ===== tb/seam_feather_pixel_blend_test.sv =====
// Self-checking testbench for the seam feather pixel blend with a predictor and random traffic.
`timescale 1ns / 100ps

module seam_feather_pixel_blend_test;
  import sfpb_pkg::*;

  localparam int SPAN         = BLEND_SPAN_DEF;
  localparam int PIPE_LATENCY = 4;
  localparam int LONG_HOLD    = 60;
  localparam int CHUNK_ITEMS  = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(8'hA5);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    rgb_t             base;
    rgb_t             warped;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [COL_W-1:0] column       = '0;
  logic [PIX_W-1:0] base_red     = '0;
  logic [PIX_W-1:0] base_green   = '0;
  logic [PIX_W-1:0] base_blue    = '0;
  logic [PIX_W-1:0] warped_red   = '0;
  logic [PIX_W-1:0] warped_green = '0;
  logic [PIX_W-1:0] warped_blue  = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;

  // Stimulus and scoreboard state.
  pixel_req_t       pixel_backlog[$];
  rgb_t             blend_expect[$];
  logic [COL_W-1:0] seam_copy = '0;
  dir_t             dir_copy  = DIR_LEFT;
  logic             req_taken = 1'b0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_trigger  = 0;
  int               hold_ack      = 0;
  int               hold_left     = 0;
  int               mismatch_count = 0;

  seam_feather_pixel_blend u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .column       (column),
    .base_red     (base_red),
    .base_green   (base_green),
    .base_blue    (base_blue),
    .warped_red   (warped_red),
    .warped_green (warped_green),
    .warped_blue  (warped_blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected blend of one pixel under the current seam and direction.
  function automatic rgb_t feather_blend(pixel_req_t p, logic [COL_W-1:0] seam, dir_t dir);
    int   col_i;
    int   seam_i;
    int   dis;
    rgb_t r;
    col_i  = int'(p.column);
    seam_i = int'(seam);
    if (p.base == '0) return p.warped;
    if (p.warped == '0) return p.base;
    dis = (dir == DIR_LEFT) ? col_i - seam_i : seam_i - col_i;
    if (dis > 0 && dis < SPAN) begin
      r.red   = PIX_W'((int'(p.base.red) * dis + int'(p.warped.red) * (SPAN - dis)) / SPAN);
      r.green = PIX_W'((int'(p.base.green) * dis + int'(p.warped.green) * (SPAN - dis)) / SPAN);
      r.blue  = PIX_W'((int'(p.base.blue) * dis + int'(p.warped.blue) * (SPAN - dis)) / SPAN);
      return r;
    end
    if ((dir == DIR_LEFT && dis > 0) || (dir == DIR_RIGHT && dis >= 0)) return p.base;
    return p.warped;
  endfunction

  function automatic pixel_req_t make_req(int col, int br, int bg, int bb,
                                          int wr, int wg, int wb);
    pixel_req_t p;
    p.column       = COL_W'(col);
    p.base.red     = PIX_W'(br);
    p.base.green   = PIX_W'(bg);
    p.base.blue    = PIX_W'(bb);
    p.warped.red   = PIX_W'(wr);
    p.warped.green = PIX_W'(wg);
    p.warped.blue  = PIX_W'(wb);
    return p;
  endfunction

  // Channel values lean toward the extremes now and then.
  function automatic logic [PIX_W-1:0] rand_channel();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 6) return '0;
    if (pick < 12) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic rgb_t rand_rgb();
    rgb_t c;
    c.red   = rand_channel();
    c.green = rand_channel();
    c.blue  = rand_channel();
    return c;
  endfunction

  // Most requests land in or near the feather band around the seam.
  function automatic pixel_req_t rand_req(logic [COL_W-1:0] seam);
    pixel_req_t p;
    int         pick;
    if ($urandom_range(99, 0) < 65)
      p.column = COL_W'(int'(seam) + int'($urandom_range(500, 0)) - 250);
    else
      p.column = COL_W'($urandom);
    p.base   = rand_rgb();
    p.warped = rand_rgb();
    pick = $urandom_range(99, 0);
    if (pick < 8) p.base = '0;
    else if (pick < 16) p.warped = '0;
    else if (pick < 18) begin
      p.base   = '0;
      p.warped = '0;
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Configuration writes are issued only while the pipeline is empty.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SEAM_COLUMN) seam_copy = COL_W'(data);
    else if (idx == REG_DIRECTION) dir_copy = dir_t'(data[0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || in_valid || blend_expect.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic run_chunk(logic [CFG_DATA_W-1:0] seam, dir_t dir);
    write_register(REG_SEAM_COLUMN, seam);
    write_register(REG_DIRECTION,
                   (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(dir));
    for (int i = 0; i < CHUNK_ITEMS; i++) pixel_backlog.push_back(rand_req(COL_W'(seam)));
    wait_drained();
  endtask

  // Request driver: presents a new request once the previous one was taken.
  always @(negedge clk) begin
    pixel_req_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        item = pixel_backlog.pop_front();
        column       <= item.column;
        base_red     <= item.base.red;
        base_green   <= item.base.green;
        base_blue    <= item.base.blue;
        warped_red   <= item.warped.red;
        warped_green <= item.warped.green;
        warped_blue  <= item.warped.blue;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with an occasional long hold-off to back up the pipeline.
  always @(negedge clk) begin
    if (hold_trigger != hold_ack) begin
      hold_ack  <= hold_trigger;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Monitor: records accepted requests and checks each delivered pixel.
  always @(posedge clk) begin
    pixel_req_t req;
    rgb_t       want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blend_expect.size() == 0) begin
          report_mismatch("unexpected pixel, out_red", int'(out_red), 0);
        end else begin
          want = blend_expect.pop_front();
          if (out_red !== want.red)
            report_mismatch("out_red", int'(out_red), int'(want.red));
          if (out_green !== want.green)
            report_mismatch("out_green", int'(out_green), int'(want.green));
          if (out_blue !== want.blue)
            report_mismatch("out_blue", int'(out_blue), int'(want.blue));
        end
      end
      if (in_valid && !in_stall) begin
        req = '{column, '{base_red, base_green, base_blue},
                '{warped_red, warped_green, warped_blue}};
        blend_expect.push_back(feather_blend(req, seam_copy, dir_copy));
      end
      req_taken <= in_valid && !in_stall;
    end
  end

  // Test sequence.
  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 69;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed checks, left mode: empty pixels, the seam itself and both band edges.
    write_register(REG_SEAM_COLUMN, 13'd300);
    write_register(REG_DIRECTION, CFG_DATA_W'(DIR_LEFT));
    pixel_backlog.push_back(make_req(300, 0, 0, 0, 10, 20, 30));
    pixel_backlog.push_back(make_req(300, 0, 0, 0, 0, 0, 0));
    pixel_backlog.push_back(make_req(300, 255, 255, 255, 0, 0, 0));
    pixel_backlog.push_back(make_req(300, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(301, 255, 0, 128, 0, 255, 127));
    pixel_backlog.push_back(make_req(499, 255, 0, 128, 0, 255, 127));
    pixel_backlog.push_back(make_req(500, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(299, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(8191, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(0, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(400, 255, 255, 255, 255, 255, 255));
    pixel_backlog.push_back(make_req(350, 1, 0, 0, 0, 0, 1));
    wait_drained();

    // Directed checks, right mode: the seam itself now selects the base pixel.
    write_register(REG_DIRECTION, CFG_DATA_W'(DIR_RIGHT));
    pixel_backlog.push_back(make_req(300, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(299, 255, 0, 128, 0, 255, 127));
    pixel_backlog.push_back(make_req(101, 255, 0, 128, 0, 255, 127));
    pixel_backlog.push_back(make_req(100, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(301, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(0, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(8191, 90, 80, 70, 10, 20, 30));
    pixel_backlog.push_back(make_req(200, 0, 0, 0, 255, 255, 255));
    pixel_backlog.push_back(make_req(200, 255, 255, 255, 0, 0, 0));
    pixel_backlog.push_back(make_req(200, 1, 1, 1, 254, 254, 254));
    wait_drained();

    // Random traffic, busy sender and slow receiver.
    run_chunk(13'd0, DIR_LEFT);
    run_chunk(13'd8191, DIR_RIGHT);

    // Random traffic, slow sender and busy receiver.
    send_idle_pct = 69;
    recv_idle_pct = 34;
    run_chunk(CFG_DATA_W'($urandom), DIR_LEFT);
    run_chunk(CFG_DATA_W'($urandom), DIR_RIGHT);

    // Full rate; the first chunk starts behind a long receiver hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger++;
    run_chunk(13'd100, DIR_RIGHT);
    write_register(REG_UNUSED, CFG_DATA_W'($urandom));
    run_chunk(13'd8100, DIR_LEFT);
    run_chunk(CFG_DATA_W'($urandom), dir_t'($urandom_range(1, 0)));

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
